[hdl/wlms_pkg.sv]
package wlms_pkg;

	localparam int RADIUS    = 16;
	localparam int MAX_WIDTH = 1024;
	localparam int RING_ROWS = 3 * RADIUS + 1;
	localparam int MAX_ROWS  = 4095;

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W   = $clog2(MAX_ROWS + 1);
	localparam int RING_W  = $clog2(RING_ROWS);
	localparam int ADDR_W  = RING_W + COL_W;
	localparam int DEPTH   = RING_ROWS * (2 ** COL_W);
	localparam int LIN_W   = $clog2(MAX_WIDTH * MAX_ROWS);
	localparam int PIX_W   = 8;
	localparam int CFG_W   = 12;

	localparam logic [1:0] REG_MIN_PEAK = 2'd0;
	localparam logic [1:0] REG_WIDTH    = 2'd1;
	localparam logic [1:0] REG_HEIGHT   = 2'd2;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;

	// one window evaluation request
	typedef struct packed {
		logic [RING_W-1:0]  ring;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   h;
		logic [WIDTH_W-1:0] w;
		logic [PIX_W-1:0]   minv;
	} judge_cmd_t;

	typedef struct packed {
		logic             done;
		logic [PIX_W-1:0] result;
	} judge_rsp_t;

endpackage

[hdl/wlms_line_ram.sv]
module wlms_line_ram (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [wlms_pkg::ADDR_W-1:0] wr_addr,
	input  logic [wlms_pkg::PIX_W-1:0]  wr_data,
	input  logic [wlms_pkg::ADDR_W-1:0] rd_addr,
	output logic [wlms_pkg::PIX_W-1:0]  rd_data
);
	import wlms_pkg::*;

	logic [PIX_W-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[hdl/wlms_judge.sv]
module wlms_judge (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  wlms_pkg::judge_cmd_t        cmd,
	output logic [wlms_pkg::ADDR_W-1:0] rd_addr,
	input  logic [wlms_pkg::PIX_W-1:0]  rd_data,
	output wlms_pkg::judge_rsp_t        rsp
);
	import wlms_pkg::*;

	typedef enum logic [1:0] {J_IDLE, J_CTR, J_CTRW, J_SCAN} jstate_t;

	jstate_t            state_q;
	logic [RING_W-1:0]  ctr_ring_q, yr_q;
	logic [COL_W-1:0]   ctr_col_q, x_q, c0_q, c1_q;
	logic [ROW_W-1:0]   y_q, r1_q;
	logic [PIX_W-1:0]   p_q, minv_q, result_q;
	logic               fail_q, done_q;
	logic               vld_s1, last_s1;

	logic [ROW_W-1:0]   r0, dr;
	logic [RING_W:0]    ring_up;
	logic [RING_W-1:0]  ring0;
	logic [ROW_W:0]     r_hi;
	logic [ROW_W-1:0]   r1;
	logic [WIDTH_W:0]   c_hi;
	logic [COL_W-1:0]   c0, c1;
	logic               x_end, scan_last, hit;

	// clipped window bounds for a new request
	always_comb begin
		dr      = (cmd.row >= ROW_W'(RADIUS)) ? ROW_W'(RADIUS) : cmd.row;
		r0      = cmd.row - dr;
		ring_up = (RING_W + 1)'(cmd.ring) + (RING_W + 1)'(RING_ROWS);
		ring0   = ({1'b0, cmd.ring} >= (RING_W + 1)'(dr))
			? RING_W'({1'b0, cmd.ring} - (RING_W + 1)'(dr))
			: RING_W'(ring_up - (RING_W + 1)'(dr));
		r_hi    = {1'b0, cmd.row} + (ROW_W + 1)'(RADIUS);
		r1      = (r_hi < {1'b0, cmd.h}) ? r_hi[ROW_W-1:0] : cmd.h - 1'b1;
		c0      = (cmd.col >= COL_W'(RADIUS)) ? cmd.col - COL_W'(RADIUS) : '0;
		c_hi    = (WIDTH_W + 1)'(cmd.col) + (WIDTH_W + 1)'(RADIUS);
		c1      = (c_hi < {1'b0, cmd.w}) ? c_hi[COL_W-1:0]
			: COL_W'(cmd.w - 1'b1);
	end

	assign x_end     = (x_q == c1_q);
	assign scan_last = x_end && (y_q == r1_q);
	assign hit       = vld_s1 && (rd_data > p_q);
	assign rd_addr   = (state_q == J_SCAN) ? {yr_q, x_q} : {ctr_ring_q, ctr_col_q};
	assign rsp       = '{done: done_q, result: result_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= J_IDLE;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
			fail_q  <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			vld_s1  <= (state_q == J_SCAN);
			last_s1 <= (state_q == J_SCAN) && scan_last;
			if (hit) begin
				fail_q <= 1'b1;
			end
			if (last_s1) begin
				done_q   <= 1'b1;
				result_q <= (fail_q || hit || (p_q < minv_q)) ? '0 : p_q;
			end
			unique case (state_q)
				J_IDLE: begin
					if (start) begin
						ctr_ring_q <= cmd.ring;
						ctr_col_q  <= cmd.col;
						minv_q     <= cmd.minv;
						y_q        <= r0;
						yr_q       <= ring0;
						r1_q       <= r1;
						x_q        <= c0;
						c0_q       <= c0;
						c1_q       <= c1;
						fail_q     <= 1'b0;
						state_q    <= J_CTR;
					end
				end
				J_CTR: state_q <= J_CTRW;
				J_CTRW: begin
					p_q     <= rd_data;
					state_q <= J_SCAN;
				end
				J_SCAN: begin
					if (x_end) begin
						x_q  <= c0_q;
						y_q  <= y_q + 1'b1;
						yr_q <= (yr_q == RING_W'(RING_ROWS - 1)) ? '0 : yr_q + 1'b1;
					end else begin
						x_q <= x_q + 1'b1;
					end
					if (scan_last) begin
						state_q <= J_IDLE;
					end
				end
				default: state_q <= J_IDLE;
			endcase
		end
	end

endmodule

[hdl/window_local_max_suppress.sv]
// channel  dir  signals                      word contents
// s_       in   tvalid tready tdata tuser    tdata[7:0] pixel_in, tuser mode
// m_       out  tvalid tready tdata tlast    tdata[7:0] pixel_out, tlast frame_last
// cfg_     in   wr_en index data             0 min peak, 1 width, 2 height
//
// One word at a time. A pixel word is written into the row ring at its accept edge; if it
// releases a result, scan the window around the output pixel through the single read port,
// one pixel per cycle. Input then stalls until the window scan ends, sooner where the
// window is clipped; words that release nothing are taken without a stall.
// A finished result only holds the input while the word ahead of it still waits on m_tready.
// Reset clears all counters; the line memory is not cleared and is only read where written.
module window_local_max_suppress (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] pixel_in
	input  logic        s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] pixel_out
	output logic        m_tlast,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [wlms_pkg::CFG_W-1:0] cfg_data
);
	import wlms_pkg::*;

	typedef enum logic [1:0] {T_IDLE, T_BUSY, T_PUSH} tstate_t;

	tstate_t            state_q;
	logic [PIX_W-1:0]   cfg_min_q, act_min_q;
	logic [WIDTH_W-1:0] cfg_w_q, act_w_q;
	logic [ROW_W-1:0]   cfg_h_q, act_h_q;
	logic [COL_W-1:0]   in_col_q, out_col_q;
	logic [ROW_W-1:0]   in_row_q, out_row_q;
	logic [RING_W-1:0]  in_ring_q, out_ring_q;
	logic [LIN_W-1:0]   lin_q;
	logic               frame_done_q, last_q;
	logic [PIX_W-1:0]   res_q;
	logic               m_tvalid_q, m_tlast_q;
	logic [PIX_W-1:0]   m_tdata_q;

	logic               acc, is_pix, is_drain, first, col_wrap, row_wrap;
	logic               emit, out_last, out_col_wrap, slot_free;
	logic [WIDTH_W-1:0] eff_w, w_sat;
	logic [ROW_W-1:0]   eff_h;
	logic [LIN_W-1:0]   lag;
	judge_cmd_t         cmd;
	judge_rsp_t         rsp;
	logic [ADDR_W-1:0]  rd_addr;
	logic [PIX_W-1:0]   rd_data;

	assign s_tready  = (state_q == T_IDLE);
	assign acc       = s_tvalid && s_tready;
	assign is_pix    = acc && (s_tuser == MODE_PIXEL);
	assign is_drain  = acc && (s_tuser == MODE_DRAIN);
	assign first     = (in_row_q == '0) && (in_col_q == '0);
	assign eff_w     = first ? cfg_w_q : act_w_q;
	assign eff_h     = first ? cfg_h_q : act_h_q;
	assign col_wrap  = (WIDTH_W'(in_col_q) + 1'b1) >= eff_w;
	assign row_wrap  = ((ROW_W + 1)'(in_row_q) + 1'b1) >= (ROW_W + 1)'(eff_h);
	assign lag       = LIN_W'(eff_w) * LIN_W'(RADIUS) + LIN_W'(RADIUS);
	assign emit      = (is_pix && (lin_q >= lag)) || (is_drain && frame_done_q);
	assign out_last  = (out_row_q == act_h_q - 1'b1) &&
		(WIDTH_W'(out_col_q) == act_w_q - 1'b1);
	assign out_col_wrap = (WIDTH_W'(out_col_q) + 1'b1) >= act_w_q;
	assign slot_free = !m_tvalid_q || m_tready;

	// clamp width to 1..MAX_WIDTH on write
	assign w_sat = (cfg_data[WIDTH_W-1:0] == '0) ? WIDTH_W'(1)
		: (cfg_data[WIDTH_W-1:0] > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH)
		: cfg_data[WIDTH_W-1:0];

	assign cmd = '{ring: out_ring_q, row: out_row_q, col: out_col_q,
		h: act_h_q, w: act_w_q, minv: act_min_q};

	wlms_line_ram u_ram (
		.clk     (clk),
		.wr_en   (is_pix),
		.wr_addr ({in_ring_q, in_col_q}),
		.wr_data (s_tdata),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	wlms_judge u_judge (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (emit),
		.cmd     (cmd),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.rsp     (rsp)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// configuration shadow registers, taken into the active set at frame start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_min_q <= PIX_W'(16);
			cfg_w_q   <= WIDTH_W'(640);
			cfg_h_q   <= ROW_W'(480);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MIN_PEAK: cfg_min_q <= cfg_data[PIX_W-1:0];
				REG_WIDTH:    cfg_w_q   <= w_sat;
				REG_HEIGHT:   cfg_h_q   <= (cfg_data[ROW_W-1:0] == '0) ? ROW_W'(1)
					: cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= T_IDLE;
			act_min_q    <= PIX_W'(16);
			act_w_q      <= WIDTH_W'(640);
			act_h_q      <= ROW_W'(480);
			in_col_q     <= '0;
			in_row_q     <= '0;
			in_ring_q    <= '0;
			lin_q        <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			out_ring_q   <= '0;
			frame_done_q <= 1'b0;
			last_q       <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_tlast_q    <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (is_pix) begin
				// a new frame drops results still pending from the last one
				if (frame_done_q) begin
					frame_done_q <= 1'b0;
					out_col_q    <= '0;
					out_row_q    <= '0;
					out_ring_q   <= '0;
				end
				if (first) begin
					act_min_q <= cfg_min_q;
					act_w_q   <= cfg_w_q;
					act_h_q   <= cfg_h_q;
				end
				if (col_wrap) begin
					in_col_q <= '0;
					if (row_wrap) begin
						in_row_q     <= '0;
						in_ring_q    <= '0;
						lin_q        <= '0;
						frame_done_q <= 1'b1;
					end else begin
						in_row_q  <= in_row_q + 1'b1;
						in_ring_q <= (in_ring_q == RING_W'(RING_ROWS - 1)) ? '0
							: in_ring_q + 1'b1;
						lin_q     <= lin_q + 1'b1;
					end
				end else begin
					in_col_q <= in_col_q + 1'b1;
					lin_q    <= lin_q + 1'b1;
				end
			end

			// advance the output position once the window request is handed off
			if (emit) begin
				last_q  <= out_last;
				state_q <= T_BUSY;
				if (out_last) begin
					out_col_q    <= '0;
					out_row_q    <= '0;
					out_ring_q   <= '0;
					frame_done_q <= 1'b0;
				end else if (out_col_wrap) begin
					out_col_q  <= '0;
					out_row_q  <= out_row_q + 1'b1;
					out_ring_q <= (out_ring_q == RING_W'(RING_ROWS - 1)) ? '0
						: out_ring_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end

			unique case (state_q)
				T_IDLE: ;
				T_BUSY: begin
					if (rsp.done) begin
						res_q <= rsp.result;
						if (slot_free) begin
							m_tvalid_q <= 1'b1;
							m_tdata_q  <= rsp.result;
							m_tlast_q  <= last_q;
							state_q    <= T_IDLE;
						end else begin
							state_q <= T_PUSH;
						end
					end
				end
				T_PUSH: begin
					if (slot_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= res_q;
						m_tlast_q  <= last_q;
						state_q    <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> state_q == T_BUSY)
		else $error("window result without a pending request");

	assert property (@(posedge clk) disable iff (!arst_n)
		frame_done_q |-> (in_col_q == '0) && (in_row_q == '0))
		else $error("frame marked done while input is mid-frame");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_ring_q < RING_W'(RING_ROWS)) && (out_ring_q < RING_W'(RING_ROWS)))
		else $error("row ring index out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> state_q == T_IDLE)
		else $error("window request while busy");

endmodule
